// ===== src/isf_pkg.sv =====
// ----------------------------------------------------------------------------
// isf_pkg
// Shared types, constants and helpers for the integral state feedback block.
// ----------------------------------------------------------------------------
package isf_pkg;

  localparam int DATA_W      = 32;
  localparam int PERIOD_W    = 24;
  localparam int SLOT_W      = 4;
  localparam int CFG_IDX_W   = 2;
  localparam int NUM_TRACKED = 2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_REF_FIRST     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REF_SECOND    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_PERIOD = 2'd2;

  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 24'd167772;

  // Input command codes.
  localparam logic CMD_GAIN_WRITE = 1'b0;
  localparam logic CMD_ELEMENT    = 1'b1;

  localparam logic signed [63:0] S32_MAX = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [63:0] S32_MIN = 64'shFFFF_FFFF_8000_0000;

  typedef struct packed {
    logic gain_wr;   // store a gain word from the input word
    logic elem_wr;   // store a state element from the input word
    logic op_load;   // load the multiplier operand register
    logic op_track;  // operand is a tracking error, else a state element
    logic mul_en;    // capture a product
    logic mul_step;  // multiply the tracking sum by the sample period
    logic acc_clr;
    logic acc_en;
    logic integ_wr;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic out_busy;
  } dp_stat_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > S32_MAX) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < S32_MIN) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// ===== src/isf_ifs.sv =====
// ----------------------------------------------------------------------------
// isf channel interfaces
// Input, result and configuration channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface isf_in_if;
  import isf_pkg::*;
  logic                     valid;
  logic                     ready;
  logic                     command;
  logic [SLOT_W-1:0]        gain_slot;
  logic signed [DATA_W-1:0] data_value;
  modport source (output valid, command, gain_slot, data_value, input ready);
  modport sink   (input valid, command, gain_slot, data_value, output ready);
endinterface

interface isf_out_if;
  import isf_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] drive_value;
  logic                     drive_channel;
  logic                     last_drive;
  modport source (output valid, drive_value, drive_channel, last_drive, input ready);
  modport sink   (input valid, drive_value, drive_channel, last_drive, output ready);
endinterface

interface isf_cfg_if;
  import isf_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [DATA_W-1:0]    data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== src/isf_ctrl.sv =====
// ----------------------------------------------------------------------------
// isf_ctrl
// Sequencer: accepts input words and steps the datapath through the
// tracking, integration and feedback multiply-accumulates per actuator.
// ----------------------------------------------------------------------------
module isf_ctrl #(
  parameter int NS = 4,
  parameter int NA = 2,
  parameter int CW = 2,
  parameter int AW = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_command,
  output logic              in_ready,
  output isf_pkg::dp_cmd_t  cmd,
  input  isf_pkg::dp_stat_t stat,
  output logic [CW-1:0]     elem_idx,
  output logic [CW-1:0]     term,
  output logic [AW-1:0]     act
);
  import isf_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_T_RD  = 4'd1;
  localparam logic [3:0] S_T_MUL = 4'd2;
  localparam logic [3:0] S_T_ACC = 4'd3;
  localparam logic [3:0] S_S_MUL = 4'd4;
  localparam logic [3:0] S_S_ADD = 4'd5;
  localparam logic [3:0] S_F_RD  = 4'd6;
  localparam logic [3:0] S_F_MUL = 4'd7;
  localparam logic [3:0] S_F_ACC = 4'd8;
  localparam logic [3:0] S_DRIVE = 4'd9;

  localparam logic [CW-1:0] LAST_ELEM = CW'(NS - 1);
  localparam logic [CW-1:0] LAST_TRK  = CW'(NUM_TRACKED - 1);
  localparam logic [AW-1:0] LAST_ACT  = AW'(NA - 1);

  logic [3:0]    state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] term_r, term_nxt;
  logic [AW-1:0] act_r, act_nxt;
  logic          accept;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign elem_idx = cnt_r;
  assign term     = term_r;
  assign act      = act_r;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    term_nxt  = term_r;
    act_nxt   = act_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_command == CMD_GAIN_WRITE) begin
            cmd.gain_wr = 1'b1;
          end else begin
            cmd.elem_wr = 1'b1;
            if (cnt_r == LAST_ELEM) begin
              cnt_nxt     = '0;
              act_nxt     = '0;
              term_nxt    = '0;
              cmd.acc_clr = 1'b1;
              state_nxt   = S_T_RD;
            end else begin
              cnt_nxt = cnt_r + 1'b1;
            end
          end
        end
      end
      S_T_RD: begin
        cmd.op_load  = 1'b1;
        cmd.op_track = 1'b1;
        state_nxt    = S_T_MUL;
      end
      S_T_MUL: begin
        cmd.mul_en = 1'b1;
        state_nxt  = S_T_ACC;
      end
      S_T_ACC: begin
        cmd.acc_en = 1'b1;
        if (term_r == LAST_TRK) begin
          state_nxt = S_S_MUL;
        end else begin
          term_nxt  = term_r + 1'b1;
          state_nxt = S_T_RD;
        end
      end
      S_S_MUL: begin
        cmd.mul_en   = 1'b1;
        cmd.mul_step = 1'b1;
        state_nxt    = S_S_ADD;
      end
      S_S_ADD: begin
        cmd.integ_wr = 1'b1;
        cmd.acc_clr  = 1'b1;
        term_nxt     = '0;
        state_nxt    = S_F_RD;
      end
      S_F_RD: begin
        cmd.op_load = 1'b1;
        state_nxt   = S_F_MUL;
      end
      S_F_MUL: begin
        cmd.mul_en = 1'b1;
        state_nxt  = S_F_ACC;
      end
      S_F_ACC: begin
        cmd.acc_en = 1'b1;
        if (term_r == LAST_ELEM) begin
          state_nxt = S_DRIVE;
        end else begin
          term_nxt  = term_r + 1'b1;
          state_nxt = S_F_RD;
        end
      end
      S_DRIVE: begin
        // Hold here until the output register can take the word.
        if (!stat.out_busy) begin
          cmd.out_load = 1'b1;
          if (act_r == LAST_ACT) begin
            state_nxt = S_IDLE;
          end else begin
            act_nxt     = act_r + 1'b1;
            term_nxt    = '0;
            cmd.acc_clr = 1'b1;
            state_nxt   = S_T_RD;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      term_r  <= '0;
      act_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      term_r  <= term_nxt;
      act_r   <= act_nxt;
    end
  end

endmodule

// ===== src/isf_dp.sv =====
// ----------------------------------------------------------------------------
// isf_dp
// Datapath: gain memory, sample store, configuration registers, one shared
// multiplier with accumulator, integrators and the output register.
// ----------------------------------------------------------------------------
module isf_dp #(
  parameter int NS = 4,
  parameter int NA = 2,
  parameter int CW = 2,
  parameter int AW = 1
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  isf_pkg::dp_cmd_t                 cmd,
  output isf_pkg::dp_stat_t                stat,
  input  logic [CW-1:0]                    elem_idx,
  input  logic [CW-1:0]                    term,
  input  logic [AW-1:0]                    act,
  input  logic [isf_pkg::SLOT_W-1:0]       gain_slot,
  input  logic signed [isf_pkg::DATA_W-1:0] data_value,
  isf_cfg_if.sink                          cfg_ch,
  isf_out_if.source                        out_ch
);
  import isf_pkg::*;

  localparam int GW    = NA * NS + NA * NUM_TRACKED;
  localparam int GAW   = $clog2(GW);
  localparam int ACC_W = 48 + $clog2(NS) + 1;

  localparam logic [31:0]    GW_32  = 32'(GW);
  localparam logic [GAW-1:0] NS_G   = GAW'(NS);
  localparam logic [GAW-1:0] TRK_G  = GAW'(NUM_TRACKED);
  localparam logic [GAW-1:0] TBASE  = GAW'(NA * NS);
  localparam logic [AW-1:0]  LAST_A = AW'(NA - 1);

  logic signed [DATA_W-1:0]   gain_mem [GW];
  logic signed [DATA_W-1:0]   gain_rd_r;
  logic signed [DATA_W-1:0]   sample_r [NS];
  logic signed [DATA_W-1:0]   ref0_r, ref1_r;
  logic [PERIOD_W-1:0]        period_r;
  logic signed [DATA_W-1:0]   operand_r;
  logic signed [63:0]         prod_r;
  logic signed [ACC_W-1:0]    acc_r;
  logic signed [DATA_W-1:0]   integ_r [NA];
  logic                       out_valid_r;
  logic signed [DATA_W-1:0]   out_value_r;
  logic                       out_chan_r;
  logic                       out_last_r;

  logic                       slot_ok;
  logic [GAW-1:0]             wr_addr, rd_addr;
  logic signed [DATA_W-1:0]   x_sel, ref_sel, err;
  logic signed [DATA_W-1:0]   mul_a, mul_b;
  logic signed [63:0]         integ_sum, drive_sum;

  assign cfg_ch.ready = 1'b1;

  // Gain memory: one write port, one registered read port.
  assign slot_ok = {{(32 - SLOT_W){1'b0}}, gain_slot} < GW_32;
  assign wr_addr = GAW'(gain_slot);
  assign rd_addr = cmd.op_track ? (TBASE + GAW'(act) * TRK_G + GAW'(term))
                                : (GAW'(act) * NS_G + GAW'(term));

  always_ff @(posedge clk) begin
    if (cmd.gain_wr && slot_ok) begin
      gain_mem[wr_addr] <= data_value;
    end
    gain_rd_r <= gain_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.elem_wr) begin
      sample_r[elem_idx] <= data_value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref0_r   <= '0;
      ref1_r   <= '0;
      period_r <= PERIOD_RESET;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        CFG_REF_FIRST:     ref0_r   <= cfg_ch.data;
        CFG_REF_SECOND:    ref1_r   <= cfg_ch.data;
        CFG_SAMPLE_PERIOD: period_r <= cfg_ch.data[PERIOD_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Tracking error, saturated, for the tracked state selected by term.
  assign x_sel   = sample_r[term];
  assign ref_sel = term[0] ? ref1_r : ref0_r;
  assign err     = sat32(64'(ref_sel) - 64'(x_sel));

  assign mul_a = cmd.mul_step ? sat32(64'(acc_r)) : gain_rd_r;
  assign mul_b = cmd.mul_step ? $signed({{(DATA_W - PERIOD_W){1'b0}}, period_r}) : operand_r;

  always_ff @(posedge clk) begin
    if (cmd.op_load) begin
      operand_r <= cmd.op_track ? err : x_sel;
    end
    if (cmd.mul_en) begin
      prod_r <= 64'(mul_a) * 64'(mul_b);
    end
    if (cmd.acc_clr) begin
      acc_r <= '0;
    end else if (cmd.acc_en) begin
      acc_r <= acc_r + ACC_W'(prod_r >>> 16);
    end
  end

  // Integration step uses the product of the tracking sum and sample period.
  assign integ_sum = 64'(integ_r[act]) + (prod_r >>> 24);
  assign drive_sum = 64'(integ_r[act]) - 64'(acc_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NA; i++) begin
        integ_r[i] <= '0;
      end
    end else if (cmd.integ_wr) begin
      integ_r[act] <= sat32(integ_sum);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_value_r <= sat32(drive_sum);
      out_chan_r  <= act[0];
      out_last_r  <= (act == LAST_A);
    end
  end

  assign stat.out_busy        = out_valid_r && !out_ch.ready;
  assign out_ch.valid         = out_valid_r;
  assign out_ch.drive_value   = out_value_r;
  assign out_ch.drive_channel = out_chan_r;
  assign out_ch.last_drive    = out_last_r;

endmodule

// ===== src/integral_state_feedback.sv =====
// A gain word or a non-final state element is taken while the block stays idle.
// The final element of a sample steps every actuator in turn through the
// single shared multiplier, which does each multiply-accumulate in three steps;
// input waits until the last drive word is loaded, and a busy output stalls it.
// Reset clears the integrators and element counter and restores the register
// defaults; gain words and stored elements are undefined until written.
// ----------------------------------------------------------------------------
// integral_state_feedback
// State feedback with integral action in signed Q16.16: integrates weighted
// tracking errors per actuator and emits integrator minus state feedback.
// ----------------------------------------------------------------------------
module integral_state_feedback #(
  parameter int NUM_STATE_ELEMENTS = 4,
  parameter int NUM_ACTUATORS      = 2
) (
  input  logic      clk,
  input  logic      rst_n,
  isf_in_if.sink    in_ch,
  isf_out_if.source out_ch,
  isf_cfg_if.sink   cfg_ch
);
  import isf_pkg::*;

  localparam int CW = $clog2(NUM_STATE_ELEMENTS);
  localparam int AW = (NUM_ACTUATORS > 1) ? $clog2(NUM_ACTUATORS) : 1;

  dp_cmd_t       cmd;
  dp_stat_t      stat;
  logic [CW-1:0] elem_idx;
  logic [CW-1:0] term;
  logic [AW-1:0] act;
  logic          in_ready;

  assign in_ch.ready = in_ready;

  isf_ctrl #(
    .NS (NUM_STATE_ELEMENTS),
    .NA (NUM_ACTUATORS),
    .CW (CW),
    .AW (AW)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_command (in_ch.command),
    .in_ready   (in_ready),
    .cmd        (cmd),
    .stat       (stat),
    .elem_idx   (elem_idx),
    .term       (term),
    .act        (act)
  );

  isf_dp #(
    .NS (NUM_STATE_ELEMENTS),
    .NA (NUM_ACTUATORS),
    .CW (CW),
    .AW (AW)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .elem_idx   (elem_idx),
    .term       (term),
    .act        (act),
    .gain_slot  (in_ch.gain_slot),
    .data_value (in_ch.data_value),
    .cfg_ch     (cfg_ch),
    .out_ch     (out_ch)
  );

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: integral state feedback regression
// Streams gain words and state samples into the block, keeps a cycle-free
// model of the integrators and feedback sums in 64-bit signed arithmetic,
// and checks every drive word, field by field, while both channels stall.
// ----------------------------------------------------------------------------
module tb;
  import isf_pkg::*;

  localparam int NUM_ELEMS      = 4;
  localparam int NUM_ACT        = 2;
  localparam int FB_WORDS       = NUM_ACT * NUM_ELEMS;
  localparam int GAIN_WORDS     = FB_WORDS + NUM_ACT * NUM_TRACKED;
  localparam int SETTLE_CYCLES  = 60;
  localparam int LONG_HOLD      = 400;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int NUM_PHASES     = 5;
  localparam int PHASE_WORDS    = 185;
  localparam int MAX_REPORTS    = 40;

  typedef struct packed {
    logic                     cmd;
    logic [SLOT_W-1:0]        slot;
    logic signed [DATA_W-1:0] data;
  } isf_word_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     channel;
    logic                     last;
  } drive_word_t;

  typedef enum int {RX_OPEN, RX_RANDOM, RX_PERIODIC} rx_mode_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  isf_in_if  in_if();
  isf_out_if out_if();
  isf_cfg_if cfg_if();

  // Values driven onto the channels, known from time zero.
  logic                     in_valid_q   = 1'b0;
  logic                     in_command_q = 1'b0;
  logic [SLOT_W-1:0]        in_slot_q    = '0;
  logic [DATA_W-1:0]        in_data_q    = '0;
  logic                     out_ready_q  = 1'b0;
  logic                     cfg_valid_q  = 1'b0;
  logic [CFG_IDX_W-1:0]     cfg_index_q  = '0;
  logic [DATA_W-1:0]        cfg_data_q   = '0;

  assign in_if.valid       = in_valid_q;
  assign in_if.command     = in_command_q;
  assign in_if.gain_slot   = in_slot_q;
  assign in_if.data_value  = in_data_q;
  assign out_if.ready      = out_ready_q;
  assign cfg_if.valid      = cfg_valid_q;
  assign cfg_if.index      = cfg_index_q;
  assign cfg_if.data       = cfg_data_q;

  integral_state_feedback #(
    .NUM_STATE_ELEMENTS(NUM_ELEMS),
    .NUM_ACTUATORS     (NUM_ACT)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_if),
    .out_ch(out_if),
    .cfg_ch(cfg_if)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Controller model
  // --------------------------------------------------------------------------
  longint              gain_words [GAIN_WORDS];
  longint              state_elems [NUM_ELEMS];
  longint              integ [NUM_ACT];
  longint              ref_angle [NUM_TRACKED];
  logic [PERIOD_W-1:0] period_q24;
  int                  elem_pos;
  drive_word_t         drive_expected [$];

  function automatic longint clamp_s32(input longint v);
    if (v > S32_MAX) begin
      return S32_MAX;
    end
    if (v < S32_MIN) begin
      return S32_MIN;
    end
    return v;
  endfunction

  task automatic reset_controller();
    int i;
    for (i = 0; i < GAIN_WORDS; i++) begin
      gain_words[i] = 0;
    end
    for (i = 0; i < NUM_ELEMS; i++) begin
      state_elems[i] = 0;
    end
    for (i = 0; i < NUM_ACT; i++) begin
      integ[i] = 0;
    end
    ref_angle[0] = 0;
    ref_angle[1] = 0;
    period_q24   = PERIOD_RESET;
    elem_pos     = 0;
  endtask

  task automatic load_register(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
    case (idx)
      CFG_REF_FIRST:     ref_angle[0] = longint'($signed(value));
      CFG_REF_SECOND:    ref_angle[1] = longint'($signed(value));
      CFG_SAMPLE_PERIOD: period_q24   = value[PERIOD_W-1:0];
      default: ;
    endcase
  endtask

  task automatic advance_controller(input isf_word_t w);
    longint      err;
    longint      track_sum;
    longint      fb_sum;
    longint      step;
    drive_word_t d;
    int          a;
    int          j;
    if (w.cmd == CMD_GAIN_WRITE) begin
      if (w.slot < GAIN_WORDS) begin
        gain_words[w.slot] = longint'(w.data);
      end
    end else begin
      state_elems[elem_pos] = longint'(w.data);
      if (elem_pos < NUM_ELEMS - 1) begin
        elem_pos++;
      end else begin
        elem_pos = 0;
        for (a = 0; a < NUM_ACT; a++) begin
          track_sum = 0;
          fb_sum    = 0;
          for (j = 0; j < NUM_TRACKED; j++) begin
            err = clamp_s32(ref_angle[j] - state_elems[j]);
            track_sum += (gain_words[FB_WORDS + a * NUM_TRACKED + j] * err) >>> 16;
          end
          // The clamped error sum is scaled by the Q0.24 period before it
          // is folded into the integrator.
          track_sum = clamp_s32(track_sum);
          step      = (track_sum * longint'(period_q24)) >>> 24;
          integ[a]  = clamp_s32(integ[a] + step);
          for (j = 0; j < NUM_ELEMS; j++) begin
            fb_sum += (gain_words[a * NUM_ELEMS + j] * state_elems[j]) >>> 16;
          end
          d.value   = 32'(clamp_s32(integ[a] - fb_sum));
          d.channel = a[0];
          d.last    = (a == NUM_ACT - 1);
          drive_expected.push_back(d);
        end
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Monitor: model update on accepted words, result check, mismatch count
  // --------------------------------------------------------------------------
  logic        in_taken  = 1'b0;
  logic        cfg_taken = 1'b0;
  int          mismatch_count = 0;
  drive_word_t exp_drive;

  task automatic report_mismatch(input string msg);
    if (mismatch_count < MAX_REPORTS) begin
      $display("[%0t] MISMATCH: %s", $realtime, msg);
    end
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    in_taken  <= in_if.valid && in_if.ready;
    cfg_taken <= cfg_if.valid && cfg_if.ready;
    if (!rst_n) begin
      reset_controller();
    end else begin
      if (cfg_if.valid && cfg_if.ready) begin
        load_register(cfg_if.index, cfg_if.data);
      end
      if (out_if.valid && out_if.ready) begin
        if (drive_expected.size() == 0) begin
          report_mismatch($sformatf("drive word with nothing expected, value %0d channel %0d",
                                    out_if.drive_value, out_if.drive_channel));
        end else begin
          exp_drive = drive_expected.pop_front();
          if (out_if.drive_value !== exp_drive.value) begin
            report_mismatch($sformatf("drive_value got %0d expected %0d on channel %0d",
                                      out_if.drive_value, exp_drive.value, exp_drive.channel));
          end
          if (out_if.drive_channel !== exp_drive.channel) begin
            report_mismatch($sformatf("drive_channel got %0b expected %0b",
                                      out_if.drive_channel, exp_drive.channel));
          end
          if (out_if.last_drive !== exp_drive.last) begin
            report_mismatch($sformatf("last_drive got %0b expected %0b on channel %0d",
                                      out_if.last_drive, exp_drive.last, exp_drive.channel));
          end
        end
      end
      if (in_if.valid && in_if.ready) begin
        advance_controller({in_if.command, in_if.gain_slot, in_if.data_value});
      end
    end
  end

  // --------------------------------------------------------------------------
  // Driver: bursts of words from the pending queue with random gaps
  // --------------------------------------------------------------------------
  isf_word_t stim_words [$];
  isf_word_t cur_word   = '0;
  logic      word_held  = 1'b0;
  int        burst_left = 0;
  int        gap_left   = 0;

  always @(negedge clk) begin
    if (!rst_n) begin
      word_held = 1'b0;
      in_valid_q <= 1'b0;
    end else if (!word_held || in_taken) begin
      word_held = 1'b0;
      if (gap_left != 0) begin
        gap_left--;
      end else if (stim_words.size() != 0) begin
        cur_word  = stim_words.pop_front();
        word_held = 1'b1;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 40);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end
      end
      in_valid_q   <= word_held;
      in_command_q <= cur_word.cmd;
      in_slot_q    <= cur_word.slot;
      in_data_q    <= cur_word.data;
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: its own stall pattern, plus a long hold on request
  // --------------------------------------------------------------------------
  int          hold_requests = 0;
  int          hold_seen     = 0;
  int          hold_left     = 0;
  int          mode_left     = 0;
  int unsigned rx_phase      = 0;
  rx_mode_t    rx_mode       = RX_OPEN;

  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready_q <= 1'b0;
    end else begin
      if (hold_seen != hold_requests) begin
        hold_seen = hold_requests;
        hold_left = LONG_HOLD;
      end
      if (mode_left == 0) begin
        rx_mode   = rx_mode_t'($urandom_range(0, 2));
        mode_left = $urandom_range(20, 200);
      end else begin
        mode_left--;
      end
      rx_phase++;
      if (hold_left != 0) begin
        hold_left--;
        out_ready_q <= 1'b0;
      end else begin
        case (rx_mode)
          RX_OPEN:   out_ready_q <= 1'b1;
          RX_RANDOM: out_ready_q <= 1'($urandom_range(0, 1));
          default:   out_ready_q <= (rx_phase % 8) >= 3;
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: too long without any handshake ends the run
  // --------------------------------------------------------------------------
  int idle_cycles = 0;

  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("Watchdog: no handshake for %0d cycles, %0d drive words outstanding",
               WATCHDOG_LIMIT, drive_expected.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  function automatic logic [DATA_W-1:0] pick_value();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 4) begin
      return $urandom_range(0, 32'h7_FFFF) - 32'h4_0000;
    end
    if (r < 7) begin
      return $urandom_range(0, 32'h7FFF) - 32'h4000;
    end
    if (r < 9) begin
      return $urandom();
    end
    case ($urandom_range(0, 4))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      default: return 32'h0000_0001;
    endcase
  endfunction

  // Mostly state elements, so samples complete often; gain words are
  // reloaded along the way and a few writes hit the unused slots.
  function automatic isf_word_t pick_word();
    isf_word_t   w;
    int unsigned r;
    r      = $urandom_range(0, 99);
    w.slot = SLOT_W'($urandom());
    w.data = pick_value();
    if (r < 14) begin
      w.cmd  = CMD_GAIN_WRITE;
      w.slot = SLOT_W'($urandom_range(0, GAIN_WORDS - 1));
    end else if (r < 17) begin
      w.cmd  = CMD_GAIN_WRITE;
      w.slot = SLOT_W'($urandom_range(GAIN_WORDS, (1 << SLOT_W) - 1));
    end else begin
      w.cmd = CMD_ELEMENT;
    end
    return w;
  endfunction

  task automatic queue_word(input logic cmd, input logic [SLOT_W-1:0] slot,
                            input logic [DATA_W-1:0] data);
    stim_words.push_back({cmd, slot, data});
  endtask

  task automatic queue_random(input int count);
    isf_word_t w;
    int        done;
    done = 0;
    while (done < count) begin
      w = pick_word();
      stim_words.push_back(w);
      if (w.cmd == CMD_ELEMENT || w.slot < GAIN_WORDS) begin
        done++;
      end
    end
  endtask

  // Returns at a falling edge once every word is accepted, every drive word
  // has arrived and the block has had time to finish trailing gain writes.
  task automatic wait_for_quiet();
    while (stim_words.size() != 0 || word_held || drive_expected.size() != 0) begin
      @(negedge clk);
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
    cfg_valid_q <= 1'b1;
    cfg_index_q <= idx;
    cfg_data_q  <= value;
    do begin
      @(negedge clk);
    end while (!cfg_taken);
  endtask

  initial begin
    int                  ph;
    int                  i;
    logic [DATA_W-1:0]   ref_a;
    logic [DATA_W-1:0]   ref_b;
    logic [DATA_W-1:0]   cfg_word;
    logic [PERIOD_W-1:0] per;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed part at the reset register values. Every gain word is loaded
    // before the first sample, with full-scale words in both gain sets.
    for (i = 0; i < GAIN_WORDS; i++) begin
      case (i)
        0, FB_WORDS:        queue_word(CMD_GAIN_WRITE, SLOT_W'(i), 32'h7FFF_FFFF);
        1, GAIN_WORDS - 1:  queue_word(CMD_GAIN_WRITE, SLOT_W'(i), 32'h8000_0000);
        default: begin
          if (i % 2 == 1) begin
            queue_word(CMD_GAIN_WRITE, SLOT_W'(i), 32'(-(i + 1) * 32'h2000));
          end else begin
            queue_word(CMD_GAIN_WRITE, SLOT_W'(i), 32'((i + 1) * 32'h3000));
          end
        end
      endcase
    end
    // Unused slots must leave the gain set alone.
    queue_word(CMD_GAIN_WRITE, SLOT_W'(GAIN_WORDS), 32'h7FFF_FFFF);
    queue_word(CMD_GAIN_WRITE, 4'hF, 32'h8000_0000);
    queue_word(CMD_ELEMENT, 4'h0, 32'h7FFF_FFFF);
    queue_word(CMD_ELEMENT, 4'h0, 32'h8000_0000);
    queue_word(CMD_ELEMENT, 4'h0, 32'h0000_0000);
    queue_word(CMD_ELEMENT, 4'h0, 32'hFFFF_FFFF);
    queue_word(CMD_ELEMENT, 4'h0, 32'h8000_0000);
    queue_word(CMD_ELEMENT, 4'h0, 32'h7FFF_FFFF);
    queue_word(CMD_ELEMENT, 4'h0, 32'h0001_0000);
    queue_word(CMD_ELEMENT, 4'h0, 32'h0000_0001);
    queue_word(CMD_ELEMENT, 4'hF, 32'hFFFF_0000);
    queue_word(CMD_ELEMENT, 4'hF, 32'h0000_8000);
    queue_word(CMD_ELEMENT, 4'hF, 32'h7FFF_FFFF);
    queue_word(CMD_ELEMENT, 4'hF, 32'h8000_0000);
    wait_for_quiet();

    // Each phase reprograms all registers while the block is idle, then
    // runs random words. Moderate settings come first, since the extreme
    // ones drive the integrators into saturation.
    for (ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: begin
          ref_a = 32'h0001_0000;
          ref_b = 32'hFFFF_8000;
          per   = PERIOD_RESET;
        end
        1: begin
          ref_a = $urandom_range(0, 32'h6_4880) - 32'h3_2440;
          ref_b = $urandom_range(0, 32'h6_4880) - 32'h3_2440;
          per   = PERIOD_W'($urandom_range(0, 24'hFF_FFFF));
        end
        2: begin
          ref_a = 32'h7FFF_FFFF;
          ref_b = 32'h8000_0000;
          per   = 24'hFF_FFFF;
        end
        3: begin
          ref_a = 32'h8000_0000;
          ref_b = 32'h7FFF_FFFF;
          per   = 24'h00_0000;
        end
        default: begin
          ref_a = $urandom();
          ref_b = $urandom();
          per   = PERIOD_W'($urandom_range(0, 24'hFF_FFFF));
        end
      endcase
      cfg_word                 = $urandom();
      cfg_word[PERIOD_W-1:0]   = per;
      write_register(CFG_REF_FIRST, ref_a);
      write_register(CFG_REF_SECOND, ref_b);
      write_register(CFG_SAMPLE_PERIOD, cfg_word);
      cfg_valid_q <= 1'b0;
      // The receiver goes quiet for a long stretch while words keep coming,
      // so the block backs up into its input.
      if (ph == 1) begin
        hold_requests++;
      end
      queue_random(PHASE_WORDS);
      wait_for_quiet();
    end

    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== integral_state_feedback.f =====
src/isf_pkg.sv
src/isf_ifs.sv
src/isf_ctrl.sv
src/isf_dp.sv
src/integral_state_feedback.sv
tb/tb.sv
